// File: rtl/video_test_pattern_generator_unit_defines.svh
// Assertion macros shared by the files that check their own logic.
`ifndef VIDEO_TEST_PATTERN_GENERATOR_UNIT_DEFINES_SVH
`define VIDEO_TEST_PATTERN_GENERATOR_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define VTPG_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define VTPG_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/vtpg_pkg.sv
package vtpg_pkg;

  localparam int ColW   = 10;
  localparam int RowW   = 9;
  localparam int FrameW = 16;
  localparam int ChanW  = 8;

  localparam int PipeStages = 5;

  // Coordinates compared against frame bounds of up to 2048 pixels.
  localparam int CoordW   = 12;
  localparam int LinePosW = 11;

  // The moving line advances 20 pixels per frame.
  localparam int LineStep  = 20;
  localparam int LineXW    = 21;
  localparam int LineLeft  = 3;
  localparam int LineRight = 4;

  // Stripes: period 96, width 46, offset (18 * frame) mod 96, which equals
  // 6 * ((3 * frame) mod 16).
  localparam int StripePeriod = 96;
  localparam int StripeWidth  = 46;
  localparam int StripeUnit   = 6;

  // Checker cells are 45 pixels; floor(v / 45) = (v * 1457) >> 16 for v < 2048.
  localparam int                   CellRecipW = 11;
  localparam logic [CellRecipW-1:0] CellRecip = 11'd1457;
  localparam int                   CellShift  = 16;

  localparam int BarRows     = 250;
  localparam int BorderInset = 10;
  localparam int BorderThick = 6;
  localparam int BoxX0       = 145;
  localparam int BoxX1       = 495;
  localparam int BoxY0       = 132;
  localparam int BoxY1       = 228;

  typedef enum logic [1:0] {
    PAT_BARS    = 2'd0,
    PAT_STRIPES = 2'd1,
    PAT_CHECKER = 2'd2
  } pattern_e;

  typedef struct packed {
    logic [ChanW-1:0] red;
    logic [ChanW-1:0] green;
    logic [ChanW-1:0] blue;
  } rgb_t;

  localparam rgb_t ColBlack  = '{8'd0, 8'd0, 8'd0};
  localparam rgb_t ColWhite  = '{8'd255, 8'd255, 8'd255};
  localparam rgb_t ColGrey   = '{8'd28, 8'd28, 8'd28};
  localparam rgb_t ColBack   = '{8'd14, 8'd26, 8'd54};
  localparam rgb_t ColCyan   = '{8'd32, 8'd180, 8'd220};
  localparam rgb_t ColYellow = '{8'd250, 8'd220, 8'd80};
  localparam rgb_t ColRed    = '{8'd244, 8'd86, 8'd86};
  localparam rgb_t ColDark   = '{8'd30, 8'd30, 8'd30};

  typedef struct packed {
    logic [ColW-1:0]   col;
    logic [LineXW-1:0] line_x;
    logic [6:0]        stripe_cm;
    logic [3:0]        stripe_oi;
    logic              cell_odd;
    logic              in_frame;
    logic              bar_zone;
    logic [2:0]        bar_idx;
    logic              border;
    logic              dark_box;
  } geom_t;

  typedef struct packed {
    logic [ColW-1:0]     col;
    logic [LinePosW-1:0] line_p;
    logic                stripe_on;
    logic                cell_odd;
    logic                in_frame;
    logic                bar_zone;
    logic [2:0]          bar_idx;
    logic                border;
    logic                dark_box;
  } shade_t;

  typedef struct packed {
    logic [PipeStages-1:0] adv;
    logic [PipeStages-1:0] vld;
  } pipe_ctl_t;

  function automatic logic [1:0] mod3_5b(input logic [4:0] v);
    logic [2:0] s;
    s = 3'(v[0]) + 3'(v[2]) + 3'(v[4]) + {1'b0, v[1], 1'b0} + {1'b0, v[3], 1'b0};
    if (s >= 3'd6) begin
      return 2'(s - 3'd6);
    end else if (s >= 3'd3) begin
      return 2'(s - 3'd3);
    end else begin
      return 2'(s);
    end
  endfunction

  function automatic rgb_t bar_color(input logic [2:0] idx);
    rgb_t c;
    unique case (idx)
      3'd0: c = ColWhite;
      3'd1: c = '{8'd255, 8'd255, 8'd0};
      3'd2: c = '{8'd0, 8'd255, 8'd255};
      3'd3: c = '{8'd0, 8'd255, 8'd0};
      3'd4: c = '{8'd255, 8'd0, 8'd255};
      3'd5: c = '{8'd0, 8'd0, 8'd255};
      3'd6: c = '{8'd255, 8'd0, 8'd0};
      3'd7: c = ColBlack;
    endcase
    return c;
  endfunction

endpackage

// File: rtl/vtpg_pix_if.sv
interface vtpg_pix_if
  import vtpg_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [ColW-1:0]   pixel_column;
  logic [RowW-1:0]   pixel_row;
  logic [FrameW-1:0] frame_index;

  modport source (output valid, pixel_column, pixel_row, frame_index, input ready);
  modport sink (input valid, pixel_column, pixel_row, frame_index, output ready);
endinterface

// File: rtl/vtpg_rgb_if.sv
interface vtpg_rgb_if
  import vtpg_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [ChanW-1:0] red;
  logic [ChanW-1:0] green;
  logic [ChanW-1:0] blue;

  modport source (output valid, red, green, blue, input ready);
  modport sink (input valid, red, green, blue, output ready);
endinterface

// File: rtl/vtpg_pipe_ctrl.sv
module vtpg_pipe_ctrl
  import vtpg_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  logic      out_ready_i,
  output pipe_ctl_t ctl_o
);

  logic [PipeStages-1:0] vld_q, vld_d, adv, prev;

  always_comb begin
    adv[PipeStages-1] = !vld_q[PipeStages-1] || out_ready_i;
    for (int k = PipeStages - 2; k >= 0; k--) begin
      adv[k] = !vld_q[k] || adv[k+1];
    end
    prev = {vld_q[PipeStages-2:0], in_valid_i};
    for (int k = 0; k < PipeStages; k++) begin
      vld_d[k] = adv[k] ? prev[k] : vld_q[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  assign ctl_o.adv = adv;
  assign ctl_o.vld = vld_q;

endmodule

// File: rtl/vtpg_geom.sv
module vtpg_geom
  import vtpg_pkg::*;
#(
  parameter int FRAME_WIDTH  = 640,
  parameter int FRAME_HEIGHT = 360
) (
  input  logic              clk_i,
  input  logic              en_i,
  input  logic [ColW-1:0]   pixel_column_i,
  input  logic [RowW-1:0]   pixel_row_i,
  input  logic [FrameW-1:0] frame_index_i,
  output geom_t             geom_o
);

  localparam logic [CoordW-1:0] XIn0  = CoordW'(BorderInset);
  localparam logic [CoordW-1:0] XIn1  = CoordW'(BorderInset + BorderThick);
  localparam logic [CoordW-1:0] XOut1 = CoordW'(FRAME_WIDTH - BorderInset);
  localparam logic [CoordW-1:0] XOut0 = CoordW'(FRAME_WIDTH - BorderInset - BorderThick);
  localparam logic [CoordW-1:0] YIn0  = CoordW'(BorderInset);
  localparam logic [CoordW-1:0] YIn1  = CoordW'(BorderInset + BorderThick);
  localparam logic [CoordW-1:0] YOut1 = CoordW'(FRAME_HEIGHT - BorderInset);
  localparam logic [CoordW-1:0] YOut0 = CoordW'(FRAME_HEIGHT - BorderInset - BorderThick);

  logic [CoordW-1:0]          col, row;
  logic [7:1]                 bar_ge;
  logic [ColW+CellRecipW-1:0] col_cell;
  logic [RowW+CellRecipW-1:0] row_cell;
  logic [5:0]                 frame_x3;
  logic                       top, bottom, left, right;
  geom_t                      geom_d, geom_q;

  assign col = CoordW'(pixel_column_i);
  assign row = CoordW'(pixel_row_i);

  for (genvar g = 1; g < 8; g++) begin : g_bound
    localparam logic [CoordW-1:0] Bound = CoordW'(g * FRAME_WIDTH / 8);
    assign bar_ge[g] = col >= Bound;
  end

  assign col_cell = (ColW+CellRecipW)'(pixel_column_i) * (ColW+CellRecipW)'(CellRecip);
  assign row_cell = (RowW+CellRecipW)'(pixel_row_i) * (RowW+CellRecipW)'(CellRecip);
  assign frame_x3 = {2'b00, frame_index_i[3:0]} + {1'b0, frame_index_i[3:0], 1'b0};

  assign top    = col >= XIn0 && col < XOut1 && row >= YIn0 && row < YIn1;
  assign bottom = col >= XIn0 && col < XOut1 && row >= YOut0 && row < YOut1;
  assign left   = col >= XIn0 && col < XIn1 && row >= YIn0 && row < YOut1;
  assign right  = col >= XOut0 && col < XOut1 && row >= YIn0 && row < YOut1;

  always_comb begin
    geom_d.bar_idx = 3'd0;
    for (int i = 1; i < 8; i++) begin
      if (bar_ge[i]) begin
        geom_d.bar_idx = 3'(i);
      end
    end
    geom_d.col       = pixel_column_i;
    geom_d.line_x    = LineXW'(frame_index_i * LineStep);
    geom_d.stripe_cm = {mod3_5b(pixel_column_i[9:5]), pixel_column_i[4:0]};
    geom_d.stripe_oi = frame_x3[3:0];
    geom_d.cell_odd  = col_cell[CellShift] ^ row_cell[CellShift] ^ frame_index_i[0];
    geom_d.in_frame  = col < CoordW'(FRAME_WIDTH) && row < CoordW'(FRAME_HEIGHT);
    geom_d.bar_zone  = row < CoordW'(BarRows);
    geom_d.border    = top || bottom || left || right;
    geom_d.dark_box  = col >= CoordW'(BoxX0) && col < CoordW'(BoxX1) &&
                       row >= CoordW'(BoxY0) && row < CoordW'(BoxY1);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      geom_q <= geom_d;
    end
  end

  assign geom_o = geom_q;

endmodule

// File: rtl/vtpg_anim.sv
module vtpg_anim
  import vtpg_pkg::*;
#(
  parameter int FRAME_WIDTH = 640
) (
  input  logic       clk_i,
  input  logic [2:0] en_i,
  input  geom_t      geom_i,
  output shade_t     shade_o
);

  // The line position is (frame * 20) mod width, reduced by a scaled
  // reciprocal whose quotient is at most one too small.
  localparam int                  RecipShift = 32;
  localparam logic [RecipShift:0] RecipFull  = (33'd1 << RecipShift) / FRAME_WIDTH;
  localparam int                  RecipW     = $clog2(RecipFull + 1);
  localparam logic [RecipW-1:0]   Recip      = RecipW'(RecipFull);
  localparam int                  ProdW      = LineXW + RecipW;
  localparam int                  QuotW      = ProdW - RecipShift;
  localparam int                  RemW       = LinePosW + 1;

  logic [ProdW-1:0]    prod_d, prod2_q;
  logic [LineXW-1:0]   x2_q, x3_q, qw_d, qw3_q, rem_full;
  logic [QuotW-1:0]    quot;
  logic [RemW-1:0]     rem;
  logic [7:0]          stripe_pos, stripe_red;
  logic                stripe_d, stripe2_q, stripe3_q;
  geom_t               g2_q, g3_q;
  shade_t              shade_d, shade_q;

  assign prod_d = ProdW'(geom_i.line_x) * ProdW'(Recip);

  always_comb begin
    stripe_pos = 8'(geom_i.stripe_cm) + 8'(StripePeriod)
               - 8'(geom_i.stripe_oi) * 8'(StripeUnit);
    stripe_red = (stripe_pos >= 8'(StripePeriod)) ? stripe_pos - 8'(StripePeriod)
                                                   : stripe_pos;
    stripe_d   = stripe_red < 8'(StripeWidth);
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      prod2_q   <= prod_d;
      x2_q      <= geom_i.line_x;
      stripe2_q <= stripe_d;
      g2_q      <= geom_i;
    end
  end

  assign quot = prod2_q[ProdW-1:RecipShift];
  assign qw_d = LineXW'(LineXW'(quot) * LineXW'(FRAME_WIDTH));

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      qw3_q     <= qw_d;
      x3_q      <= x2_q;
      stripe3_q <= stripe2_q;
      g3_q      <= g2_q;
    end
  end

  assign rem_full = x3_q - qw3_q;
  assign rem      = rem_full[RemW-1:0];

  always_comb begin
    shade_d.col       = g3_q.col;
    shade_d.line_p    = (rem >= RemW'(FRAME_WIDTH)) ? LinePosW'(rem - RemW'(FRAME_WIDTH))
                                                    : LinePosW'(rem);
    shade_d.stripe_on = stripe3_q;
    shade_d.cell_odd  = g3_q.cell_odd;
    shade_d.in_frame  = g3_q.in_frame;
    shade_d.bar_zone  = g3_q.bar_zone;
    shade_d.bar_idx   = g3_q.bar_idx;
    shade_d.border    = g3_q.border;
    shade_d.dark_box  = g3_q.dark_box;
  end

  always_ff @(posedge clk_i) begin
    if (en_i[2]) begin
      shade_q <= shade_d;
    end
  end

  assign shade_o = shade_q;

endmodule

// File: rtl/vtpg_shade.sv
module vtpg_shade
  import vtpg_pkg::*;
(
  input  logic       clk_i,
  input  logic       en_i,
  input  logic [1:0] pattern_select_i,
  input  shade_t     shade_i,
  output rgb_t       rgb_o
);

  logic [CoordW-1:0] col, pos, line_lo, line_hi;
  logic              line_hit;
  rgb_t              rgb_d, rgb_q;

  assign col      = CoordW'(shade_i.col);
  assign pos      = CoordW'(shade_i.line_p);
  assign line_lo  = (pos >= CoordW'(LineLeft)) ? pos - CoordW'(LineLeft) : '0;
  assign line_hi  = pos + CoordW'(LineRight);
  assign line_hit = col >= line_lo && col < line_hi;

  always_comb begin
    rgb_d = ColBlack;
    if (shade_i.in_frame) begin
      case (pattern_select_i)
        PAT_BARS: begin
          if (line_hit) begin
            rgb_d = ColWhite;
          end else if (shade_i.bar_zone) begin
            rgb_d = bar_color(shade_i.bar_idx);
          end else begin
            rgb_d = ColGrey;
          end
        end
        PAT_STRIPES: begin
          if (shade_i.border) begin
            rgb_d = ColYellow;
          end else if (shade_i.stripe_on) begin
            rgb_d = ColCyan;
          end else begin
            rgb_d = ColBack;
          end
        end
        PAT_CHECKER: begin
          if (shade_i.dark_box) begin
            rgb_d = ColDark;
          end else if (shade_i.cell_odd) begin
            rgb_d = ColRed;
          end else begin
            rgb_d = ColBlack;
          end
        end
        default: rgb_d = ColBlack;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rgb_q <= rgb_d;
    end
  end

  assign rgb_o = rgb_q;

endmodule

// File: rtl/video_test_pattern_generator_unit.sv
// Video test pattern generator, one RGB pixel per transaction.
// The pix_i channel carries a pixel column, row and frame number; the rgb_o
// channel returns the 8-bit red, green and blue values of that pixel. Both
// channels use valid/ready, and a transaction completes on a clock edge with
// both high. cfg_we_i writes cfg_wdata_i into the pattern select register
// (0 bars, 1 stripes, 2 checkerboard, 3 black); write it only while idle.
// The datapath is five register stages: geometry decode, reciprocal multiply,
// quotient multiply, remainder correction and color select with the output
// register. One pixel is accepted every cycle while rgb_o is not stalled.
// When rgb_o stalls, the stages hold their contents and pix_i.ready drops
// only once every stage is full; bubbles are filled first.
// Reset clears all stage valid bits and sets the pattern select to bars.
`include "video_test_pattern_generator_unit_defines.svh"

module video_test_pattern_generator_unit
  import vtpg_pkg::*;
#(
  parameter int FRAME_WIDTH  = 640,
  parameter int FRAME_HEIGHT = 360
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  vtpg_pix_if.sink   pix_i,
  vtpg_rgb_if.source rgb_o,
  input  logic       cfg_we_i,
  input  logic [1:0] cfg_wdata_i
);

  logic [1:0] pattern_select_q, pattern_select_d;
  pipe_ctl_t  ctl;
  geom_t      geom;
  shade_t     shade;
  rgb_t       rgb;

  always_comb begin
    pattern_select_d = cfg_we_i ? cfg_wdata_i : pattern_select_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pattern_select_q <= PAT_BARS;
    end else begin
      pattern_select_q <= pattern_select_d;
    end
  end

  vtpg_pipe_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (pix_i.valid),
    .out_ready_i (rgb_o.ready),
    .ctl_o       (ctl)
  );

  vtpg_geom #(
    .FRAME_WIDTH  (FRAME_WIDTH),
    .FRAME_HEIGHT (FRAME_HEIGHT)
  ) u_geom (
    .clk_i          (clk_i),
    .en_i           (ctl.adv[0]),
    .pixel_column_i (pix_i.pixel_column),
    .pixel_row_i    (pix_i.pixel_row),
    .frame_index_i  (pix_i.frame_index),
    .geom_o         (geom)
  );

  vtpg_anim #(
    .FRAME_WIDTH (FRAME_WIDTH)
  ) u_anim (
    .clk_i   (clk_i),
    .en_i    (ctl.adv[3:1]),
    .geom_i  (geom),
    .shade_o (shade)
  );

  vtpg_shade u_shade (
    .clk_i            (clk_i),
    .en_i             (ctl.adv[4]),
    .pattern_select_i (pattern_select_q),
    .shade_i          (shade),
    .rgb_o            (rgb)
  );

  assign pix_i.ready = ctl.adv[0];
  assign rgb_o.valid = ctl.vld[PipeStages-1];
  assign rgb_o.red   = rgb.red;
  assign rgb_o.green = rgb.green;
  assign rgb_o.blue  = rgb.blue;

  `VTPG_ASSERT_NOW(a_ready_chain, rgb_o.ready, pix_i.ready, "Input stalled while output ready.")
  `VTPG_ASSERT_NEXT(a_accept_loads, pix_i.valid && pix_i.ready, ctl.vld[0], "Accepted pixel lost.")
  `VTPG_ASSERT_NOW(a_full_stall, (&ctl.vld) && !rgb_o.ready, !pix_i.ready, "Full pipe accepted input.")

endmodule
